[rtl/core/life_automaton_grid_step_macros.svh]
`ifndef LIFE_AUTOMATON_GRID_STEP_MACROS_SVH
`define LIFE_AUTOMATON_GRID_STEP_MACROS_SVH

// Same-cycle implication, checked on every rising edge of clk outside reset.
`define LAG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge of clk outside reset.
`define LAG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/lag_pkg.sv]
`timescale 1ns / 1ps

package lag_pkg;

  localparam int CMD_W     = 3;
  localparam int COORD_W   = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int NB_W      = 4;
  localparam int EFF_W     = 8;
  localparam int RB_W      = 9;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 8;

  localparam logic [NB_W-1:0] SURVIVE_MIN = 4'd2;
  localparam logic [NB_W-1:0] BIRTH_CNT   = 4'd3;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 3'd0,
    CMD_TOGGLE = 3'd1,
    CMD_READ   = 3'd2,
    CMD_STEP   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_WIDTH  = 1'b0,
    REG_ACTIVE_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_RESP
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } mem_ctl_t;

endpackage

[rtl/core/life_automaton_grid_step.sv]
`timescale 1ns / 1ps
`include "life_automaton_grid_step_macros.svh"

// Bounded Game of Life grid (B3/S23) of MAX_ROWS rows by MAX_COLS columns, held as one
// row word per memory entry, with a shared row-evaluation unit under a small sequencer.
// The block takes one command at a time and raises in_tready only when idle. Cell
// commands (write, toggle, read) fetch the rows above, at and below the addressed cell
// through the single read port before they produce their result; a generation streams
// every active row through the read port, one row per cycle. Clear, unused codes and
// out-of-range coordinates go straight to the response state. The grid is cleared at
// reset and by the clear command through per-row valid flags, so no clearing pass is
// needed. A result waits in the output register until its transfer, and the next command
// is taken once that register has been loaded. Configuration writes must be made while
// the block is idle; out-of-range register values are clamped to 1..MAX_COLS and
// 1..MAX_ROWS.

module life_automaton_grid_step import lag_pkg::*; #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // command[2:0], col[8:3], row[14:9], cell_value[15]
  input  logic [IN_W-1:0]      in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // cell_alive[0], live_neighbours[4:1], status[5], zero fill[7:6]
  output logic [OUT_W-1:0]     out_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int CA = $clog2(MAX_COLS);
  localparam int RA = $clog2(MAX_ROWS);

  state_t               state_r, state_nxt;
  logic [CFG_W-1:0]     aw_r, aw_nxt, ah_r, ah_nxt;
  logic [EFF_W-1:0]     eff_w, eff_h;

  logic [CMD_W-1:0]     in_cmd;
  logic [COORD_W-1:0]   in_col, in_row;
  logic                 in_val;

  logic [CMD_W-1:0]     cmd_r, cmd_nxt;
  logic [COORD_W-1:0]   col_r, col_nxt, row_r, row_nxt;
  logic                 val_r, val_nxt;
  logic [RB_W-1:0]      ra_b_r, ra_b_nxt, end_b_r, end_b_nxt, arr_b_r, arr_b_nxt;
  logic                 arr_vld_r, arr_vld_nxt;
  logic [MAX_COLS-1:0]  prev_r, prev_nxt, cur_r, cur_nxt;

  logic                 res_alive_r, res_alive_nxt, res_status_r, res_status_nxt;
  logic [NB_W-1:0]      res_nb_r, res_nb_nxt;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic                 out_alive_r, out_alive_nxt, out_status_r, out_status_nxt;
  logic [NB_W-1:0]      out_nb_r, out_nb_nxt;

  mem_ctl_t             mem_ctl;
  logic [RA-1:0]        rd_addr, wr_addr;
  logic [MAX_COLS-1:0]  wr_data, rd_word, unit_row;
  logic [NB_W-1:0]      unit_cnt;
  logic [CA-1:0]        col_idx;
  logic [RA-1:0]        row_idx;
  logic                 new_bit;

  assign in_cmd = in_tdata[CMD_W-1:0];
  assign in_col = in_tdata[CMD_W+COORD_W-1:CMD_W];
  assign in_row = in_tdata[CMD_W+2*COORD_W-1:CMD_W+COORD_W];
  assign in_val = in_tdata[CMD_W+2*COORD_W];

  assign col_idx = CA'(col_r);
  assign row_idx = RA'(row_r);

  always_comb begin
    eff_w = EFF_W'(aw_r);
    if (aw_r == '0) begin
      eff_w = EFF_W'(1);
    end else if (EFF_W'(aw_r) > EFF_W'(MAX_COLS)) begin
      eff_w = EFF_W'(MAX_COLS);
    end
    eff_h = EFF_W'(ah_r);
    if (ah_r == '0) begin
      eff_h = EFF_W'(1);
    end else if (EFF_W'(ah_r) > EFF_W'(MAX_ROWS)) begin
      eff_h = EFF_W'(MAX_ROWS);
    end
  end

  lag_row_mem #(
    .ROWS (MAX_ROWS),
    .COLS (MAX_COLS),
    .RA   (RA)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_word (rd_word)
  );

  lag_row_unit #(
    .COLS (MAX_COLS),
    .CA   (CA)
  ) u_unit (
    .above     (prev_r),
    .mid       (cur_r),
    .below     (rd_word),
    .eff_w     (eff_w),
    .sel_col   (col_idx),
    .next_row  (unit_row),
    .sel_count (unit_cnt)
  );

  always_comb begin
    state_nxt      = state_r;
    aw_nxt         = aw_r;
    ah_nxt         = ah_r;
    cmd_nxt        = cmd_r;
    col_nxt        = col_r;
    row_nxt        = row_r;
    val_nxt        = val_r;
    ra_b_nxt       = ra_b_r;
    end_b_nxt      = end_b_r;
    arr_b_nxt      = arr_b_r;
    arr_vld_nxt    = 1'b0;
    prev_nxt       = prev_r;
    cur_nxt        = cur_r;
    res_alive_nxt  = res_alive_r;
    res_nb_nxt     = res_nb_r;
    res_status_nxt = res_status_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_alive_nxt  = out_alive_r;
    out_nb_nxt     = out_nb_r;
    out_status_nxt = out_status_r;
    mem_ctl        = '0;
    rd_addr        = RA'(ra_b_r - RB_W'(1));
    wr_addr        = RA'(arr_b_r - RB_W'(2));
    wr_data        = unit_row;
    new_bit        = (cmd_r == CMD_WRITE) ? val_r : !cur_r[col_idx];

    if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_WIDTH:  aw_nxt = cfg_wdata;
        REG_ACTIVE_HEIGHT: ah_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt        = in_cmd;
          col_nxt        = in_col;
          row_nxt        = in_row;
          val_nxt        = in_val;
          prev_nxt       = '0;
          cur_nxt        = '0;
          res_alive_nxt  = 1'b0;
          res_nb_nxt     = '0;
          res_status_nxt = 1'b0;
          state_nxt      = S_RESP;
          unique case (in_cmd) inside
            CMD_WRITE, CMD_TOGGLE, CMD_READ: begin
              if (EFF_W'(in_col) < eff_w && EFF_W'(in_row) < eff_h) begin
                // Row counters are biased by one so the row above row 0 is index 0.
                ra_b_nxt  = RB_W'(in_row);
                end_b_nxt = RB_W'(in_row) + RB_W'(2);
                state_nxt = S_RUN;
              end else begin
                res_status_nxt = 1'b1;
              end
            end
            CMD_STEP: begin
              ra_b_nxt  = RB_W'(1);
              end_b_nxt = RB_W'(eff_h) + RB_W'(1);
              state_nxt = S_RUN;
            end
            CMD_CLEAR: begin
              mem_ctl.clr = 1'b1;
            end
            default: ;
          endcase
        end
      end

      S_RUN: begin
        if (ra_b_r <= end_b_r) begin
          mem_ctl.rd_en = (ra_b_r != '0) && (ra_b_r <= RB_W'(eff_h));
          ra_b_nxt      = ra_b_r + RB_W'(1);
          arr_vld_nxt   = 1'b1;
          arr_b_nxt     = ra_b_r;
        end
        if (arr_vld_r) begin
          prev_nxt = cur_r;
          cur_nxt  = rd_word;
          if (cmd_r == CMD_STEP) begin
            mem_ctl.wr_en = (arr_b_r >= RB_W'(2));
          end else if (arr_b_r == end_b_r) begin
            wr_addr = row_idx;
            if (cmd_r == CMD_READ) begin
              res_alive_nxt = cur_r[col_idx];
              res_nb_nxt    = unit_cnt;
            end else begin
              wr_data          = cur_r;
              wr_data[col_idx] = new_bit;
              mem_ctl.wr_en    = 1'b1;
              res_alive_nxt    = new_bit;
            end
          end
          if (arr_b_r == end_b_r) begin
            state_nxt = S_RESP;
          end
        end
      end

      S_RESP: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_alive_nxt  = res_alive_r;
          out_nb_nxt     = res_nb_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      aw_r         <= CFG_W'(64);
      ah_r         <= CFG_W'(64);
      ra_b_r       <= '0;
      end_b_r      <= '0;
      arr_b_r      <= '0;
      arr_vld_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      aw_r         <= aw_nxt;
      ah_r         <= ah_nxt;
      ra_b_r       <= ra_b_nxt;
      end_b_r      <= end_b_nxt;
      arr_b_r      <= arr_b_nxt;
      arr_vld_r    <= arr_vld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    col_r        <= col_nxt;
    row_r        <= row_nxt;
    val_r        <= val_nxt;
    prev_r       <= prev_nxt;
    cur_r        <= cur_nxt;
    res_alive_r  <= res_alive_nxt;
    res_nb_r     <= res_nb_nxt;
    res_status_r <= res_status_nxt;
    out_alive_r  <= out_alive_nxt;
    out_nb_r     <= out_nb_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_status_r, out_nb_r, out_alive_r};

  `LAG_ASSERT_NXT(a_accept_leaves_idle, in_tvalid && in_tready, state_r != S_IDLE,
                  "accepted command did not start")
  `LAG_ASSERT_NOW(a_no_write_when_idle, state_r == S_IDLE, !mem_ctl.wr_en,
                  "grid written while idle")
  `LAG_ASSERT_NOW(a_arrival_in_bound, arr_vld_r, arr_b_r <= end_b_r,
                  "row arrived past the end of the sweep")

endmodule

[rtl/core/lag_row_mem.sv]
`timescale 1ns / 1ps

module lag_row_mem import lag_pkg::*; #(
  parameter int ROWS = 64,
  parameter int COLS = 64,
  parameter int RA   = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mem_ctl_t        ctl,
  input  logic [RA-1:0]   rd_addr,
  input  logic [RA-1:0]   wr_addr,
  input  logic [COLS-1:0] wr_data,
  output logic [COLS-1:0] rd_word
);

  logic [COLS-1:0] mem [ROWS];
  logic [COLS-1:0] rd_q_r;
  logic [ROWS-1:0] row_vld_r, row_vld_nxt;
  logic            keep_r, keep_nxt;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // A row that was never written since reset or the last clear reads as all dead.
  always_comb begin
    row_vld_nxt = row_vld_r;
    if (ctl.clr) begin
      row_vld_nxt = '0;
    end else if (ctl.wr_en) begin
      row_vld_nxt[wr_addr] = 1'b1;
    end
    keep_nxt = ctl.rd_en && row_vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      keep_r    <= 1'b0;
    end else begin
      row_vld_r <= row_vld_nxt;
      keep_r    <= keep_nxt;
    end
  end

  assign rd_word = keep_r ? rd_q_r : '0;

endmodule

[rtl/core/lag_row_unit.sv]
`timescale 1ns / 1ps

module lag_row_unit import lag_pkg::*; #(
  parameter int COLS = 64,
  parameter int CA   = 6
) (
  input  logic [COLS-1:0]  above,
  input  logic [COLS-1:0]  mid,
  input  logic [COLS-1:0]  below,
  input  logic [EFF_W-1:0] eff_w,
  input  logic [CA-1:0]    sel_col,
  output logic [COLS-1:0]  next_row,
  output logic [NB_W-1:0]  sel_count
);

  logic [COLS-1:0] mask;
  logic [COLS+1:0] pa, pm, pb;
  logic [NB_W-1:0] cnt [COLS];

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      mask[c] = (EFF_W'(c) < eff_w);
    end
  end

  // Columns outside the active width and beyond either edge count as dead.
  assign pa = {1'b0, above & mask, 1'b0};
  assign pm = {1'b0, mid & mask, 1'b0};
  assign pb = {1'b0, below & mask, 1'b0};

  for (genvar c = 0; c < COLS; c++) begin : g_col
    assign cnt[c] = NB_W'(pa[c]) + NB_W'(pa[c+1]) + NB_W'(pa[c+2]) +
                    NB_W'(pm[c]) + NB_W'(pm[c+2]) +
                    NB_W'(pb[c]) + NB_W'(pb[c+1]) + NB_W'(pb[c+2]);
    assign next_row[c] = !mask[c] ? mid[c] :
                         mid[c] ? (cnt[c] == SURVIVE_MIN || cnt[c] == BIRTH_CNT) :
                                  (cnt[c] == BIRTH_CNT);
  end

  assign sel_count = cnt[sel_col];

endmodule

[bench/life_automaton_grid_step_test.sv]
`timescale 1ns / 1ps

module life_automaton_grid_step_test;
  import lag_pkg::*;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int REPORT_LIMIT = 10;
  localparam logic [CMD_W-1:0] CMD_LAST_CODE = 3'd7;

  typedef struct packed {
    logic            alive;
    logic [NB_W-1:0] neighbours;
    logic            status;
  } cell_report_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [OUT_W-1:0]     out_tdata;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_ACTIVE_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  logic [MAX_COLS-1:0] grid [MAX_ROWS];
  logic [MAX_COLS-1:0] snapshot [MAX_ROWS];
  logic [CFG_W-1:0]    width_reg = 7'd64;
  logic [CFG_W-1:0]    height_reg = 7'd64;
  cell_report_t        expected_reports [$];
  int                  mismatches = 0;
  int                  idle_pct = 0;
  int                  stall_pct = 0;

  life_automaton_grid_step dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  function automatic int clamp_size(logic [CFG_W-1:0] v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic int cols_in_use();
    return clamp_size(width_reg, MAX_COLS);
  endfunction

  function automatic int rows_in_use();
    return clamp_size(height_reg, MAX_ROWS);
  endfunction

  // Counts live neighbours in the snapshot; cells beyond the active area are dead.
  function automatic int count_live_around(int r, int c, int w, int h);
    int n;
    int rr;
    int cc;
    n = 0;
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        rr = r + dr;
        cc = c + dc;
        if ((dr != 0 || dc != 0) && rr >= 0 && rr < h && cc >= 0 && cc < w)
          n += snapshot[rr][cc];
      end
    end
    return n;
  endfunction

  function automatic cell_report_t apply_command(logic [CMD_W-1:0] cmd, int c, int r,
                                                 logic value);
    cell_report_t rep;
    int w;
    int h;
    int n;
    rep = '0;
    w = cols_in_use();
    h = rows_in_use();
    case (cmd)
      CMD_WRITE, CMD_TOGGLE, CMD_READ: begin
        if (c >= w || r >= h) begin
          rep.status = 1'b1;
        end else begin
          if (cmd == CMD_WRITE) begin
            grid[r][c] = value;
          end else if (cmd == CMD_TOGGLE) begin
            grid[r][c] = ~grid[r][c];
          end else begin
            snapshot = grid;
            rep.neighbours = NB_W'(count_live_around(r, c, w, h));
          end
          rep.alive = grid[r][c];
        end
      end
      CMD_STEP: begin
        snapshot = grid;
        for (int rr = 0; rr < h; rr++) begin
          for (int cc = 0; cc < w; cc++) begin
            n = count_live_around(rr, cc, w, h);
            if (snapshot[rr][cc])
              grid[rr][cc] = (n == SURVIVE_MIN || n == BIRTH_CNT);
            else
              grid[rr][cc] = (n == BIRTH_CNT);
          end
        end
      end
      CMD_CLEAR: begin
        for (int rr = 0; rr < MAX_ROWS; rr++) grid[rr] = '0;
      end
      default: begin
      end
    endcase
    return rep;
  endfunction

  task automatic send_command(logic [CMD_W-1:0] cmd, int c, int r, logic value);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata <= IN_W'($urandom);
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {value, r[COORD_W-1:0], c[COORD_W-1:0], cmd};
    do @(posedge clk); while (!in_tready);
    expected_reports.push_back(apply_command(cmd, c, r, value));
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (expected_reports.size() != 0);
  endtask

  task automatic set_area(logic [CFG_W-1:0] wval, logic [CFG_W-1:0] hval);
    cfg_we <= 1'b1;
    cfg_index <= REG_ACTIVE_WIDTH;
    cfg_wdata <= wval;
    @(posedge clk);
    width_reg = wval;
    cfg_index <= REG_ACTIVE_HEIGHT;
    cfg_wdata <= hval;
    @(posedge clk);
    height_reg = hval;
    cfg_we <= 1'b0;
  endtask

  task automatic flag_mismatch(string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%s", what);
  endtask

  always @(posedge clk) begin : result_check
    cell_report_t want;
    cell_report_t got;
    out_tready <= ($urandom_range(99) >= stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      got.alive = out_tdata[0];
      got.neighbours = out_tdata[4:1];
      got.status = out_tdata[5];
      if (expected_reports.size() == 0) begin
        flag_mismatch($sformatf("Unexpected result transfer: data %h", out_tdata));
      end else begin
        want = expected_reports.pop_front();
        if (got.alive !== want.alive || got.neighbours !== want.neighbours ||
            got.status !== want.status)
          flag_mismatch($sformatf(
            "Result mismatch: expected alive %0d neighbours %0d status %0d, got %0d %0d %0d",
            want.alive, want.neighbours, want.status,
            got.alive, got.neighbours, got.status));
      end
    end
  end

  task automatic test_directed_cells();
    send_command(CMD_WRITE, 0, 0, 1'b1);
    send_command(CMD_WRITE, 63, 63, 1'b1);
    send_command(CMD_WRITE, 0, 63, 1'b0);
    send_command(CMD_READ, 0, 0, 1'b0);
    send_command(CMD_TOGGLE, 63, 63, 1'b0);
    send_command(CMD_TOGGLE, 63, 63, 1'b1);
    send_command(CMD_READ, 63, 63, 1'b0);
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        if (dr != 0 || dc != 0) send_command(CMD_WRITE, 5 + dc, 5 + dr, 1'b1);
      end
    end
    send_command(CMD_READ, 5, 5, 1'b0);
    send_command(CMD_STEP, 0, 0, 1'b0);
    send_command(CMD_READ, 5, 4, 1'b0);
    for (logic [CMD_W-1:0] k = CMD_W'(CMD_CLEAR + 1); k <= CMD_LAST_CODE && k != 0; k++)
      send_command(k, $urandom_range(63), $urandom_range(63), 1'($urandom_range(1)));
    send_command(CMD_CLEAR, 0, 0, 1'b0);
    send_command(CMD_READ, 0, 0, 1'b0);
    wait_for_results();
  endtask

  task automatic test_area_limits();
    set_area(7'd0, 7'd0);
    send_command(CMD_WRITE, 0, 0, 1'b1);
    send_command(CMD_WRITE, 1, 0, 1'b1);
    send_command(CMD_TOGGLE, 0, 1, 1'b0);
    send_command(CMD_READ, 63, 63, 1'b0);
    send_command(CMD_STEP, 0, 0, 1'b0);
    send_command(CMD_READ, 0, 0, 1'b0);
    wait_for_results();
    set_area(7'd127, 7'd127);
    send_command(CMD_READ, 63, 63, 1'b0);
    send_command(CMD_READ, 1, 0, 1'b0);
    wait_for_results();
    set_area(7'd65, 7'd3);
    send_command(CMD_WRITE, 63, 2, 1'b1);
    send_command(CMD_WRITE, 63, 3, 1'b1);
    send_command(CMD_READ, 62, 1, 1'b0);
    wait_for_results();
  endtask

  // Mostly commands inside the active area so that patterns grow and evolve,
  // with a share of out-of-area coordinates and unused codes.
  task automatic test_random_traffic(int count, int idle, int stall,
                                     logic [CFG_W-1:0] wval, logic [CFG_W-1:0] hval,
                                     int hold_every);
    int pick;
    int c;
    int r;
    logic [CMD_W-1:0] cmd;
    set_area(wval, hval);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      c = $urandom_range(cols_in_use() - 1);
      r = $urandom_range(rows_in_use() - 1);
      if (pick < 40) cmd = CMD_WRITE;
      else if (pick < 55) cmd = CMD_TOGGLE;
      else if (pick < 80) cmd = CMD_READ;
      else if (pick < 90) cmd = CMD_STEP;
      else if (pick < 91) cmd = CMD_CLEAR;
      else if (pick < 94) cmd = CMD_W'($urandom_range(CMD_LAST_CODE, CMD_CLEAR + 1));
      else begin
        cmd = CMD_W'($urandom_range(CMD_READ, CMD_WRITE));
        c = $urandom_range(63);
        r = $urandom_range(63);
      end
      send_command(cmd, c, r, 1'($urandom_range(1)));
      if (hold_every != 0 && i % hold_every == hold_every - 1) wait_for_results();
    end
    wait_for_results();
    idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    for (int rr = 0; rr < MAX_ROWS; rr++) grid[rr] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cells();
    test_area_limits();
    test_random_traffic(400, 0, 0, 7'd64, 7'd64, 0);
    test_random_traffic(400, 85, 0, 7'd8, 7'd8, 0);
    test_random_traffic(400, 0, 85, 7'd16, 7'd5, 0);
    test_random_traffic(400, 7, 7, 7'd3, 7'd12, 40);
    test_random_traffic(200, 0, 0, 7'd100, 7'd1, 0);
    test_random_traffic(200, 7, 7, 7'd12, 7'd10, 25);
    repeat (16) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/lag_pkg.sv
rtl/core/lag_row_mem.sv
rtl/core/lag_row_unit.sv
rtl/core/life_automaton_grid_step.sv
bench/life_automaton_grid_step_test.sv
